// ----- hw/rtl/lfc_pkg.sv -----
// Shared types, constants and helpers of the 5x5 Laws texture filter.
// No dependencies; every other file of the block but lfc_fifo imports this package.
`default_nettype none

package lfc_pkg;

    localparam int LFC_MAX_WIDTH  = 512;
    localparam int LFC_MAX_HEIGHT = 512;
    localparam int LFC_QUEUE_DEPTH = 4;

    localparam int CFG_DATA_W = 10;
    localparam int RESP_W     = 17;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_VERT_SELECT  = 2'd2,
        REG_HORZ_SELECT  = 2'd3
    } lfc_reg_t;

    localparam logic [0:0] CMD_PUSH  = 1'b0;
    localparam logic [0:0] CMD_FLUSH = 1'b1;

    localparam logic [2:0] VEC_R5 = 3'd4;

    // L5, E5, S5, W5, R5
    localparam logic signed [3:0] LAWS_VEC [5][5] = '{
        '{ 4'sd1,  4'sd4,  4'sd6,  4'sd4,  4'sd1},
        '{-4'sd1, -4'sd2,  4'sd0,  4'sd2,  4'sd1},
        '{-4'sd1,  4'sd0,  4'sd2,  4'sd0, -4'sd1},
        '{-4'sd1,  4'sd2,  4'sd0, -4'sd2,  4'sd1},
        '{ 4'sd1, -4'sd4,  4'sd6, -4'sd4,  4'sd1}
    };

    // One scan step handed from front to back
    typedef struct packed {
        logic [7:0]      pix;
        logic [4:0][2:0] vtap;   // line tap per window row
        logic [4:0][2:0] hsel;   // column history slot per window column
        logic            emit;
        logic            last;
    } lfc_item_t;

    // History slot (0 = newest) that holds window position b around pos,
    // with mirror extension that does not repeat the edge.
    function automatic logic [2:0] mirror_sel(input int pos, input int n, input int b);
        int v;
        int k;
        v = pos + b - 2;
        if (v < 0)
            k = 2 * pos + b;
        else if (v >= n)
            k = 2 * pos - 2 * n + 2 + b;
        else
            k = 4 - b;
        if (k < 0 || k > 4)
            k = 0;
        return 3'(k);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lfc_fifo.sv -----
// Short queue between front and back of the Laws filter.
// Generic payload width; depends on nothing else.
`default_nettype none

module lfc_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    output logic               full,
    input  wire logic          pop,
    output logic [DW-1:0]      head_data,
    output logic               empty
);
    localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CB = $clog2(DEPTH + 1);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [PB-1:0] wr_ptr_reg;
    logic [PB-1:0] rd_ptr_reg;
    logic [CB-1:0] count_reg;

    assign full      = (count_reg == CB'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PB'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PB'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lfc_front.sv -----
// Front of the Laws filter: takes commands, tracks scan and output
// positions, and works out mirror selections. Uses lfc_pkg.
`default_nettype none

module lfc_front #(
    parameter int MAX_WIDTH  = lfc_pkg::LFC_MAX_WIDTH,
    parameter int MAX_HEIGHT = lfc_pkg::LFC_MAX_HEIGHT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             clear,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   w,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]  h,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             in_cmd,
    input  wire logic [7:0]                       in_pixel,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output lfc_pkg::lfc_item_t                    q_item,
    output logic [$clog2(MAX_WIDTH)-1:0]          q_col
);
    import lfc_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int RB = $clog2(MAX_HEIGHT + 2);
    localparam int OB = $clog2(MAX_HEIGHT);
    localparam int XW = 14;

    logic [CB-1:0] scan_col_reg;
    logic [RB-1:0] scan_row_reg;
    logic [CB-1:0] out_col_reg;
    logic [OB-1:0] out_row_reg;

    logic accept;
    logic full_frame;
    logic act;
    logic emit;
    logic last;
    logic scan_eol;
    logic out_eol;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign full_frame = (XW'(scan_row_reg) >= XW'(h));
    // a push once the frame is in behaves as a flush
    assign act        = full_frame || (in_cmd == CMD_PUSH);
    assign emit       = full_frame || (scan_row_reg >= RB'(3))
                        || ((scan_row_reg == RB'(2)) && (scan_col_reg >= CB'(2)));
    assign scan_eol   = (XW'(scan_col_reg) == XW'(w) - XW'(1));
    assign out_eol    = (XW'(out_col_reg) == XW'(w) - XW'(1));
    assign last       = emit && out_eol && (XW'(out_row_reg) == XW'(h) - XW'(1));
    assign q_push     = accept && act;
    assign q_col      = scan_col_reg;

    always_comb
    begin
        q_item.pix  = in_pixel;
        q_item.emit = emit;
        q_item.last = last;
        for (int i = 0; i < 5; i++)
        begin
            q_item.vtap[i] = mirror_sel(int'(scan_row_reg) - 2, int'(h), i);
            q_item.hsel[i] = mirror_sel(int'(out_col_reg), int'(w), i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_col_reg <= '0;
            scan_row_reg <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
        end
        else if (clear || (q_push && last))
        begin
            scan_col_reg <= '0;
            scan_row_reg <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
        end
        else if (q_push)
        begin
            if (scan_eol)
            begin
                scan_col_reg <= '0;
                scan_row_reg <= scan_row_reg + 1'b1;
            end
            else
            begin
                scan_col_reg <= scan_col_reg + 1'b1;
            end
            if (emit)
            begin
                if (out_eol)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lfc_back.sv -----
// Back of the Laws filter: line memory, column history and the separable
// 5x5 sum, all stages advancing together. Uses lfc_pkg.
`default_nettype none

module lfc_back #(
    parameter int MAX_WIDTH = lfc_pkg::LFC_MAX_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [2:0]                          vsel,
    input  wire logic [2:0]                          hvsel,
    input  wire logic                                q_empty,
    input  wire lfc_pkg::lfc_item_t                  q_item,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]        q_col,
    output logic                                     q_pop,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [lfc_pkg::RESP_W-1:0]               out_resp,
    output logic                                     out_last
);
    import lfc_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);

    logic en;

    // line memory: word per column, rows r-1 (low byte) to r-4
    logic [31:0] line_mem [MAX_WIDTH];
    logic [31:0] rd_reg;

    logic            s1_valid_reg;
    lfc_item_t       s1_item_reg;
    logic [CB-1:0]   s1_col_reg;

    logic [4:0][4:0][7:0] hist_reg;
    logic [4:0][7:0]      new_col;
    logic [4:0][7:0]      taps;

    logic            s2_valid_reg;
    logic [4:0][2:0] s2_hsel_reg;
    logic            s2_last_reg;

    logic signed [12:0] vsum [5];
    logic signed [12:0] s3_vsum_reg [5];
    logic               s3_valid_reg;
    logic               s3_last_reg;

    logic signed [17:0] hsum;
    logic [RESP_W-1:0]  resp_reg;
    logic               last_reg;
    logic               valid_reg;

    assign en        = !valid_reg || out_ready;
    assign q_pop     = en && !q_empty;
    assign out_valid = valid_reg;
    assign out_resp  = resp_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_reg <= line_mem[q_col];
        end
        if (en && s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= {rd_reg[23:0], s1_item_reg.pix};
        end
    end

    // form the vertically mirrored column of the current scan step
    always_comb
    begin
        taps[0] = s1_item_reg.pix;
        taps[1] = rd_reg[7:0];
        taps[2] = rd_reg[15:8];
        taps[3] = rd_reg[23:16];
        taps[4] = rd_reg[31:24];
        for (int a = 0; a < 5; a++)
        begin
            case (s1_item_reg.vtap[a])
                3'd0:    new_col[a] = taps[0];
                3'd1:    new_col[a] = taps[1];
                3'd2:    new_col[a] = taps[2];
                3'd3:    new_col[a] = taps[3];
                3'd4:    new_col[a] = taps[4];
                default: new_col[a] = taps[0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= q_item;
            s1_col_reg  <= q_col;
            if (s1_valid_reg)
            begin
                hist_reg[0] <= new_col;
                for (int k = 1; k < 5; k++)
                begin
                    hist_reg[k] <= hist_reg[k-1];
                end
            end
            s2_hsel_reg <= s1_item_reg.hsel;
            s2_last_reg <= s1_item_reg.last;
        end
    end

    // vertical pass over each window column
    always_comb
    begin
        logic [2:0]      vs;
        logic [4:0][7:0] wcol;
        vs = (vsel > VEC_R5) ? VEC_R5 : vsel;
        for (int b = 0; b < 5; b++)
        begin
            case (s2_hsel_reg[b])
                3'd0:    wcol = hist_reg[0];
                3'd1:    wcol = hist_reg[1];
                3'd2:    wcol = hist_reg[2];
                3'd3:    wcol = hist_reg[3];
                3'd4:    wcol = hist_reg[4];
                default: wcol = hist_reg[0];
            endcase
            vsum[b] = '0;
            for (int a = 0; a < 5; a++)
            begin
                vsum[b] = vsum[b] + $signed({5'b0, wcol[a]}) * 13'(LAWS_VEC[vs][a]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int b = 0; b < 5; b++)
            begin
                s3_vsum_reg[b] <= vsum[b];
            end
            s3_last_reg <= s2_last_reg;
            resp_reg    <= hsum[RESP_W-1:0];
            last_reg    <= s3_last_reg;
        end
    end

    // horizontal pass
    always_comb
    begin
        logic [2:0] hs;
        hs   = (hvsel > VEC_R5) ? VEC_R5 : hvsel;
        hsum = '0;
        for (int b = 0; b < 5; b++)
        begin
            hsum = hsum + 18'(s3_vsum_reg[b]) * 18'(LAWS_VEC[hs][b]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= !q_empty;
            s2_valid_reg <= s1_valid_reg && s1_item_reg.emit;
            s3_valid_reg <= s2_valid_reg;
            valid_reg    <= s3_valid_reg;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/laws_filter_convolution_5x5.sv -----
// Path: an input transfer is queued, then passes stages s1, s2 and s3 and
// the output register before its result appears on the output.
// Throughput: one item per cycle; the back pipeline moves as a unit and
// holds only while its output register waits, the 4-entry queue absorbs it.
// Each item does one read and one write of the single-port-pair line memory.
// Reset (rst_n, asynchronous) restores registers and counters; the line
// memory needs no clearing, as every pixel read was written in the frame.
`default_nettype none

module laws_filter_convolution_5x5 #(
    parameter int MAX_WIDTH  = lfc_pkg::LFC_MAX_WIDTH,
    parameter int MAX_HEIGHT = lfc_pkg::LFC_MAX_HEIGHT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // [7:0] pixel
    input  wire logic [0:0]                    s_axis_tuser,   // [0] command
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [23:0]                        m_axis_tdata,   // [16:0] response
    output logic                               m_axis_tlast,   // last_of_frame
    input  wire logic                          cfg_wen,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [lfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lfc_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int CB = $clog2(MAX_WIDTH);
    localparam int DW = CB + $bits(lfc_item_t);

    logic [9:0] width_reg;
    logic [9:0] height_reg;
    logic [2:0] vsel_reg;
    logic [2:0] hsel_reg;
    logic       dim_clear;

    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 10'd512;
            height_reg <= 10'd512;
            vsel_reg   <= '0;
            hsel_reg   <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (lfc_reg_t'(cfg_addr))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                REG_VERT_SELECT:  vsel_reg   <= cfg_wdata[2:0];
                REG_HORZ_SELECT:  hsel_reg   <= cfg_wdata[2:0];
                default:          ;
            endcase
        end
    end

    assign dim_clear = cfg_wen && ((lfc_reg_t'(cfg_addr) == REG_IMAGE_WIDTH)
                                   || (lfc_reg_t'(cfg_addr) == REG_IMAGE_HEIGHT));

    always_comb
    begin
        if (14'(width_reg) < 14'd3)
            w_eff = WB'(3);
        else if (14'(width_reg) > 14'(MAX_WIDTH))
            w_eff = WB'(MAX_WIDTH);
        else
            w_eff = WB'(width_reg);
        if (14'(height_reg) < 14'd3)
            h_eff = HB'(3);
        else if (14'(height_reg) > 14'(MAX_HEIGHT))
            h_eff = HB'(MAX_HEIGHT);
        else
            h_eff = HB'(height_reg);
    end

    logic          q_full;
    logic          q_push;
    lfc_item_t     f_item;
    logic [CB-1:0] f_col;
    logic          q_pop;
    logic          q_empty;
    logic [DW-1:0] q_head;
    lfc_item_t     b_item;
    logic [CB-1:0] b_col;
    logic [RESP_W-1:0] resp;

    lfc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (dim_clear),
        .w        (w_eff),
        .h        (h_eff),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser[0]),
        .in_pixel (s_axis_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (f_item),
        .q_col    (f_col)
    );

    lfc_fifo #(
        .DW    (DW),
        .DEPTH (LFC_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_col, f_item}),
        .full      (q_full),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty)
    );

    assign b_item = q_head[$bits(lfc_item_t)-1:0];
    assign b_col  = q_head[DW-1:$bits(lfc_item_t)];

    lfc_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .vsel      (vsel_reg),
        .hvsel     (hsel_reg),
        .q_empty   (q_empty),
        .q_item    (b_item),
        .q_col     (b_col),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_resp  (resp),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, resp};

endmodule

`default_nettype wire

// ----- sim/lfc_checker.sv -----
// Checker for the 5x5 Laws texture filter: watches the input, output and config ports,
// predicts each response with its own frame model and compares field by field.
// Depends on lfc_pkg for register codes, command values and size limits.
`default_nettype none

module lfc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  in_pixel,
    input  wire logic [0:0]  in_cmd,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [23:0] out_data,
    input  wire logic        out_last,
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [9:0]  cfg_wdata,
    output int               errors,
    output int               pending,
    output int               responses_seen,
    output int               frames_seen
);
    import lfc_pkg::*;

    typedef struct packed {
        logic signed [16:0] response;
        logic               last;
    } filt_result_t;

    localparam int STORE_DEPTH = 4 * LFC_MAX_WIDTH + 8;

    logic [9:0]  width_reg;
    logic [9:0]  height_reg;
    logic [2:0]  vsel_reg;
    logic [2:0]  hsel_reg;
    logic [7:0]  frame_store [STORE_DEPTH];
    int          in_col, in_row, out_col, out_row;
    filt_result_t expected_q[$];

    // Laws vectors, L5 E5 S5 W5 R5
    int laws_taps [5][5] = '{
        '{ 1,  4,  6,  4,  1},
        '{-1, -2,  0,  2,  1},
        '{-1,  0,  2,  0, -1},
        '{-1,  2,  0, -2,  1},
        '{ 1, -4,  6, -4,  1}
    };

    function automatic int clamp_size(int v, int hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int reflect(int v, int n);
        if (v < 0)
            v = -v;
        if (v >= n)
            v = 2 * n - 2 - v;
        return v;
    endfunction

    task automatic predict_transfer(input logic [0:0] cmd, input logic [7:0] pix);
        int w, h, total, in_lin, out_lin, sum, vs, hs, ry, rx;
        bit fire;
        filt_result_t r;
        w = clamp_size(width_reg, LFC_MAX_WIDTH);
        h = clamp_size(height_reg, LFC_MAX_HEIGHT);
        total = w * h;
        in_lin = in_row * w + in_col;
        out_lin = out_row * w + out_col;
        fire = 0;
        if (cmd == CMD_PUSH && in_lin < total) begin
            frame_store[in_lin % STORE_DEPTH] = pix;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            in_lin++;
            if (in_lin - out_lin >= 2 * w + 3)
                fire = 1;
        end
        else if (in_lin >= total && out_lin < total)
            fire = 1;
        if (!fire)
            return;
        vs = (vsel_reg > 4) ? 4 : vsel_reg;
        hs = (hsel_reg > 4) ? 4 : hsel_reg;
        sum = 0;
        for (int a = 0; a < 5; a++)
        begin
            ry = reflect(out_row + a - 2, h);
            for (int b = 0; b < 5; b++)
            begin
                rx = reflect(out_col + b - 2, w);
                sum += int'(frame_store[(ry * w + rx) % STORE_DEPTH])
                       * laws_taps[vs][a] * laws_taps[hs][b];
            end
        end
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
        end
        r.last = 0;
        if (out_row * w + out_col >= total)
        begin
            r.last = 1;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
        r.response = 17'(sum);
        expected_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        filt_result_t e;
        if (!rst_n)
        begin
            width_reg <= 10'd512;
            height_reg <= 10'd512;
            vsel_reg <= 3'd0;
            hsel_reg <= 3'd0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            expected_q.delete();
            errors <= 0;
            pending <= 0;
            responses_seen <= 0;
            frames_seen <= 0;
        end
        else
        begin
            // compare first, so a same-edge transfer cannot satisfy its own check
            if (out_valid && out_ready)
            begin
                responses_seen <= responses_seen + 1;
                if (out_last)
                    frames_seen <= frames_seen + 1;
                if (expected_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected response %0d last %0b",
                                 $signed(out_data[16:0]), out_last);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.response !== out_data[16:0] || e.last !== out_last)
                    begin
                        if (errors < 10)
                            $display("mismatch: expected %0d/%0b, got %0d/%0b",
                                     e.response, e.last,
                                     $signed(out_data[16:0]), out_last);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_transfer(in_cmd, in_pixel);
            if (cfg_wen)
            begin
                case (lfc_reg_t'(cfg_addr))
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg <= cfg_wdata;
                        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg <= cfg_wdata;
                        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                    end
                    REG_VERT_SELECT: vsel_reg <= cfg_wdata[2:0];
                    REG_HORZ_SELECT: hsel_reg <= cfg_wdata[2:0];
                    default: ;
                endcase
            end
            pending <= expected_q.size();
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench top for laws_filter_convolution_5x5: drives frames, flushes and
// register settings, and gives the verdict. Depends on lfc_pkg and lfc_checker.
`default_nettype none

module tb;
    import lfc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] pixel
    logic [0:0]  s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [16:0] response
    logic        m_axis_tlast;
    logic        cfg_wen;
    logic [1:0]  cfg_addr;
    logic [9:0]  cfg_wdata;
    int          errors, pending, responses_seen, frames_seen;
    int          items_sent;
    bit          quiet;

    laws_filter_convolution_5x5 dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    lfc_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_pixel(s_axis_tdata), .in_cmd(s_axis_tuser),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_last(m_axis_tlast),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending),
        .responses_seen(responses_seen), .frames_seen(frames_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    // receiver: random stall bursts until the quiet tail
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send(input logic [0:0] cmd, input logic [7:0] pix);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= pix;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input lfc_reg_t idx, input logic [9:0] val);
        cfg_wen <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // one frame: pixels, a few stray early flushes, then flushes mixed with pushes to drain the tail
    task automatic run_frame(input int w, input int h, input int mode);
        logic [7:0] p;
        for (int i = 0; i < w * h; i++)
        begin
            case (mode)
                0: p = 8'($urandom);
                1: p = (i % 2) ? 8'hFF : 8'h00;
                2: p = 8'hFF;
                default: p = 8'h00;
            endcase
            if ($urandom_range(0, 30) == 0)
                send(CMD_FLUSH, 8'($urandom));
            send(CMD_PUSH, p);
        end
        for (int i = 0; i < 2 * w + 2; i++)
            send($urandom_range(0, 3) == 0 ? CMD_PUSH : CMD_FLUSH, 8'($urandom));
        send(CMD_FLUSH, 8'($urandom));
    endtask

    task automatic set_size(input int w, input int h);
        write_reg(REG_IMAGE_WIDTH, 10'(w));
        write_reg(REG_IMAGE_HEIGHT, 10'(h));
    endtask

    initial
    begin
        int w, h;
        quiet = 0;
        items_sent = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_PUSH;
        cfg_wen = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest frame, pixel extremes, vector pairs L5/L5 and R5/R5 on extremes
        set_size(3, 3);
        write_reg(REG_VERT_SELECT, 10'd0);
        write_reg(REG_HORZ_SELECT, 10'd0);
        send(CMD_FLUSH, 8'h00);
        run_frame(3, 3, 2);
        drain();
        write_reg(REG_VERT_SELECT, 10'd4);
        write_reg(REG_HORZ_SELECT, 10'd7);
        run_frame(3, 3, 1);
        drain();
        // clamp below range, abandon a frame by rewriting the size
        set_size(0, 1);
        for (int i = 0; i < 5; i++)
            send(CMD_PUSH, 8'($urandom));
        drain();
        set_size(4, 3);
        run_frame(4, 3, 3);
        drain();

        // random frames with all vector pairs
        while (items_sent < 900)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(3, 7);
            h = $urandom_range(3, 6);
            set_size(w, h);
            write_reg(REG_VERT_SELECT, 10'($urandom_range(0, 7)));
            write_reg(REG_HORZ_SELECT, 10'($urandom_range(0, 7)));
            run_frame(w, h, $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0);
            drain();
            // switch the selector mid-frame on occasion
            if ($urandom_range(0, 3) == 0)
            begin
                set_size(5, 4);
                for (int i = 0; i < 15; i++)
                    send(CMD_PUSH, 8'($urandom));
                drain();
                write_reg(REG_HORZ_SELECT, 10'($urandom_range(0, 4)));
                for (int i = 0; i < 5 + 12; i++)
                    send((i < 5) ? CMD_PUSH : CMD_FLUSH, 8'($urandom));
                drain();
            end
        end

        // largest size clamps to the maximum; push a few pixels and abandon
        write_reg(REG_IMAGE_WIDTH, 10'h3FF);
        write_reg(REG_IMAGE_HEIGHT, 10'h3FF);
        for (int i = 0; i < 16; i++)
            send(CMD_PUSH, 8'($urandom));
        drain();

        quiet = 1;
        set_size(6, 3);
        write_reg(REG_VERT_SELECT, 10'd1);
        write_reg(REG_HORZ_SELECT, 10'd3);
        run_frame(6, 3, 0);
        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d input transfers, %0d responses, %0d completed frames",
                 items_sent, responses_seen, frames_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
